>>> design/ffem_pkg.sv
// ----------------------------------------------------------------------------
// ffem_pkg
// Shared types, codes and constants of the force-feedback effect mixer.
// ----------------------------------------------------------------------------
package ffem_pkg;

  localparam int DEF_TABLE_ENTRIES = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int LIMIT_W    = 15;
  localparam int DBAND_W    = 19;
  localparam int TERM_W     = 37;

  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_DB   = 2'd2;

  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST  = 15'd20480;
  localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 15'd25600;
  localparam logic [DBAND_W-1:0] FRICTION_DB_RST   = 19'd410;

  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [2:0] KIND_CONSTANT = 3'd0;
  localparam logic [2:0] KIND_SPRING   = 3'd1;
  localparam logic [2:0] KIND_DAMPER   = 3'd2;
  localparam logic [2:0] KIND_FRICTION = 3'd3;

  typedef struct packed {
    logic               command;
    logic [7:0]         fx_id;
    logic [2:0]         effect_kind;
    logic               enable;
    logic signed [15:0] magnitude;
    logic signed [15:0] gain;
    logic signed [15:0] position;
    logic signed [19:0] velocity;
  } in_t;

  typedef struct packed {
    logic [5:0]         slot_used;
    logic               slot_overwritten;
    logic signed [15:0] torque_sum;
    logic signed [15:0] current_command;
  } out_t;

  typedef struct packed {
    logic [7:0]         id;
    logic [2:0]         kind;
    logic               en;
    logic signed [15:0] magnitude;
    logic signed [15:0] gain;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] position;
    logic signed [19:0] velocity;
    logic [DBAND_W-1:0] deadband;
  } term_ctl_t;

endpackage

>>> design/force_feedback_effect_mixer.sv
// ----------------------------------------------------------------------------
// force_feedback_effect_mixer
// Steps: each filled table entry is read in turn and the read and term
// registers drain; then a set item writes its slot, while a compute item
// is scaled, rounded and limited to a current. An empty table has no reads.
// Items are handled one at a time; the next is taken once the result is queued.
// Reset clears the fill count and handshake, reloads the limits and the
// deadband, and leaves the table contents, never read before being written.
// ----------------------------------------------------------------------------
module force_feedback_effect_mixer
  import ffem_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W  = TERM_W + IDX_W + 1;
  localparam int S10_W  = SUM_W + 4;
  localparam int RND_W  = S10_W - 16;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SETWR = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_CUR   = 3'd6;

  logic [2:0]               state_r, state_nxt;
  in_t                      item_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         rd_addr_r;
  logic                     v1_r;
  logic [IDX_W-1:0]         a1_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         hit_slot_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [S10_W-1:0]  acc10_r;
  logic signed [15:0]       tq_r;
  logic [LIMIT_W-1:0]       torque_limit_r;
  logic [LIMIT_W-1:0]       current_limit_r;
  logic [DBAND_W-1:0]       deadband_r;
  logic                     out_valid_r;
  out_t                     out_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     rd_en;
  logic                     last_rd;
  logic                     tbl_we;
  logic [IDX_W-1:0]         set_slot;
  logic                     set_over;
  entry_t                   wr_entry;
  entry_t                   rd_entry;
  term_ctl_t                term_ctl;
  logic                     term_valid;
  logic signed [TERM_W-1:0] term;
  logic signed [S10_W-1:0]  acc_x;
  logic signed [S10_W-1:0]  acc10_nxt;
  logic signed [S10_W-1:0]  biased;
  logic signed [RND_W-1:0]  rounded;
  logic signed [RND_W-1:0]  tl_x;
  logic signed [15:0]       tq_nxt;
  logic signed [19:0]       tq_x;
  logic signed [19:0]       tq10;
  logic signed [19:0]       cl_x;
  logic signed [15:0]       cur_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_en    = (state_r == S_SCAN);
  assign last_rd  = (CNT_W'(rd_addr_r) == (count_r - CNT_W'(1)));

  always_comb begin
    wr_entry.id        = item_r.fx_id;
    wr_entry.kind      = item_r.effect_kind;
    wr_entry.en        = item_r.enable;
    wr_entry.magnitude = item_r.magnitude;
    wr_entry.gain      = item_r.gain;
    set_over = 1'b0;
    if (hit_r) begin
      set_slot = hit_slot_r;
    end else if (count_r < FULL_CNT) begin
      set_slot = count_r[IDX_W-1:0];
    end else begin
      set_slot = LAST_IDX;
      set_over = 1'b1;
    end
    tbl_we = (state_r == S_SETWR) && out_free;
  end

  ffem_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (set_slot),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr_r),
    .rdata (rd_entry)
  );

  always_comb begin
    term_ctl.valid    = v1_r && (item_r.command == CMD_COMPUTE);
    term_ctl.position = item_r.position;
    term_ctl.velocity = item_r.velocity;
    term_ctl.deadband = deadband_r;
  end

  ffem_term u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (term_ctl),
    .entry      (rd_entry),
    .term_valid (term_valid),
    .term       (term)
  );

  always_comb begin
    acc_x     = {{(S10_W-SUM_W){acc_r[SUM_W-1]}}, acc_r};
    acc10_nxt = (acc_x <<< 3) + (acc_x <<< 1);
    biased    = acc10_r + S10_W'(32768);
    rounded   = RND_W'(biased >>> 16);
    tl_x      = RND_W'({1'b0, torque_limit_r});
    if (rounded > tl_x) begin
      tq_nxt = 16'(tl_x);
    end else if (rounded < -tl_x) begin
      tq_nxt = 16'(-tl_x);
    end else begin
      tq_nxt = 16'(rounded);
    end
    tq_x = {{4{tq_r[15]}}, tq_r};
    tq10 = (tq_x <<< 3) + (tq_x <<< 1);
    cl_x = {5'b0, current_limit_r};
    if (tq10 > cl_x) begin
      cur_nxt = 16'(cl_x);
    end else if (tq10 < -cl_x) begin
      cur_nxt = 16'(-cl_x);
    end else begin
      cur_nxt = 16'(tq10);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (count_r == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !term_valid) begin
          state_nxt = (item_r.command == CMD_SET) ? S_SETWR : S_SCALE;
        end
      end
      S_SETWR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCALE: state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_CUR;
      S_CUR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      count_r         <= '0;
      v1_r            <= 1'b0;
      hit_r           <= 1'b0;
      out_valid_r     <= 1'b0;
      torque_limit_r  <= TORQUE_LIMIT_RST;
      current_limit_r <= CURRENT_LIMIT_RST;
      deadband_r      <= FRICTION_DB_RST;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TORQUE_LIMIT:  torque_limit_r  <= cfg_wdata[LIMIT_W-1:0];
          REG_CURRENT_LIMIT: current_limit_r <= cfg_wdata[LIMIT_W-1:0];
          REG_FRICTION_DB:   deadband_r      <= cfg_wdata[DBAND_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        hit_r <= 1'b0;
      end else if (v1_r && !hit_r && (item_r.command == CMD_SET)
                   && (rd_entry.id == item_r.fx_id)) begin
        hit_r <= 1'b1;
      end
      if (tbl_we && !hit_r && (count_r < FULL_CNT)) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (((state_r == S_SETWR) || (state_r == S_CUR)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r    <= in_data;
      rd_addr_r <= '0;
      acc_r     <= '0;
    end else begin
      if (rd_en) begin
        rd_addr_r <= rd_addr_r + IDX_W'(1);
      end
      if (term_valid) begin
        acc_r <= acc_r + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
      end
    end
    a1_r <= rd_addr_r;
    if (v1_r && !hit_r && (rd_entry.id == item_r.fx_id)) begin
      hit_slot_r <= a1_r;
    end
    if (state_r == S_SCALE) begin
      acc10_r <= acc10_nxt;
    end
    if (state_r == S_ROUND) begin
      tq_r <= tq_nxt;
    end
    if ((state_r == S_SETWR) && out_free) begin
      out_r.slot_used        <= 6'(set_slot);
      out_r.slot_overwritten <= set_over;
      out_r.torque_sum       <= 16'sd0;
      out_r.current_command  <= 16'sd0;
    end else if ((state_r == S_CUR) && out_free) begin
      out_r.slot_used        <= 6'd0;
      out_r.slot_overwritten <= 1'b0;
      out_r.torque_sum       <= tq_r;
      out_r.current_command  <= cur_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/ffem_table.sv
// ----------------------------------------------------------------------------
// ffem_table
// Effect table: single write port, one registered read port.
// ----------------------------------------------------------------------------
module ffem_table
  import ffem_pkg::*;
#(
  parameter int ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/ffem_term.sv
// ----------------------------------------------------------------------------
// ffem_term
// Per-entry torque term at Q.16 scale, before the common factor of ten.
// ----------------------------------------------------------------------------
module ffem_term
  import ffem_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  term_ctl_t                ctl,
  input  entry_t                   entry,
  output logic                     term_valid,
  output logic signed [TERM_W-1:0] term
);

  logic signed [15:0]       a_op;
  logic signed [20:0]       b_op;
  logic signed [20:0]       pos_x;
  logic signed [20:0]       vel_x;
  logic signed [20:0]       db_x;
  logic signed [TERM_W-1:0] term_r;
  logic                     term_valid_r;

  always_comb begin
    pos_x = {{5{ctl.position[15]}}, ctl.position};
    vel_x = {ctl.velocity[19], ctl.velocity};
    db_x  = {2'b00, ctl.deadband};
    a_op  = (entry.kind == KIND_CONSTANT) ? entry.magnitude : entry.gain;
    b_op  = 21'sd0;
    if (entry.en) begin
      unique case (entry.kind)
        KIND_CONSTANT: b_op = 21'sd4096;
        KIND_SPRING:   b_op = 21'sd0 - pos_x;
        KIND_DAMPER:   b_op = 21'sd0 - vel_x;
        KIND_FRICTION: begin
          if (vel_x > db_x) begin
            b_op = -21'sd4096;
          end else if (vel_x < (21'sd0 - db_x)) begin
            b_op = 21'sd4096;
          end
        end
        default: b_op = 21'sd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_valid_r <= 1'b0;
    end else begin
      term_valid_r <= ctl.valid;
    end
    term_r <= a_op * b_op;
  end

  assign term_valid = term_valid_r;
  assign term       = term_r;

endmodule

>>> design/ffem_chk.sv
// ----------------------------------------------------------------------------
// ffem_chk
// Port-level checks of the effect mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ffem_chk
  import ffem_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_overwritten |->
      (out_data.slot_used == 6'(TABLE_ENTRIES - 1)) && (out_data.torque_sum == 16'sd0))
    else $error("overwrite reported on wrong slot");

  a_zero_torque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.torque_sum == 16'sd0) |-> out_data.current_command == 16'sd0)
    else $error("current without torque");

endmodule

bind force_feedback_effect_mixer ffem_chk #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ffem_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
